[rtl/gtph_pkg.sv]
// ----------------------------------------------------------------------------
// gtph_pkg
// Shared types, codes and constants of the go-to-point heading controller.
// ----------------------------------------------------------------------------
package gtph_pkg;

  // Fixed field widths
  localparam int ANG_W      = 16;  // binary angle, 32768 = pi
  localparam int CMD_W      = 16;  // velocity commands
  localparam int SPD_W      = 15;  // speed settings
  localparam int TOL_W      = 14;  // heading tolerance
  localparam int DTOL_W     = 15;  // distance tolerance
  localparam int MODE_W     = 3;
  localparam int CFG_ADDR_W = 3;

  // CORDIC internals: angles with pi = 2^31
  localparam int ATAN_DEPTH = 24;
  localparam int IDX_W      = 5;
  localparam int ACC_W      = 33;
  localparam int ANG_FRAC   = 16;
  localparam int PROD_W     = 2 * DTOL_W;

  // Normalization: leading one brought up to bit NORM_BIT
  localparam int NORM_BIT     = 30;
  localparam int COARSE_BIT   = 22;
  localparam int COARSE_SHIFT = 8;

  localparam logic [ANG_W-1:0] HALF_TURN    = 16'h8000;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 16'h4000;

  // Register reset values
  localparam logic [TOL_W-1:0]  HTOL_RST = 14'd546;
  localparam logic [DTOL_W-1:0] DTOL_RST = 15'd77;
  localparam logic [SPD_W-1:0]  FWD_RST  = 15'd0;
  localparam logic [SPD_W-1:0]  TURN_RST = 15'd26;
  localparam logic [SPD_W-1:0]  FINE_RST = 15'd26;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_X  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_Y  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEAD_TOL  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIST_TOL  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FWD_SPEED = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_TURN_SPD  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_FINE_SPD  = 3'd6;

  typedef enum logic [0:0] {
    OP_POSE = 1'b0,
    OP_MODE = 1'b1
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WAITING = 3'd0,
    MODE_INIT    = 3'd1,
    MODE_EXEC    = 3'd2,
    MODE_PAUSE   = 3'd3,
    MODE_STOP    = 3'd4
  } run_mode_t;

  typedef enum logic [1:0] {
    NAV_FIX      = 2'd0,
    NAV_STRAIGHT = 2'd1,
    NAV_DONE     = 2'd2
  } nav_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_NORM,
    S_CORDIC,
    S_ANGLE,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_D,
    S_DECIDE,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OUT_ZERO,
    OUT_DONE,
    OUT_FINE,
    OUT_COARSE,
    OUT_FWD
  } out_kind_t;

  typedef enum logic [1:0] {
    MUL_X,
    MUL_Y,
    MUL_D
  } mul_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;
    logic             prep;
    logic             norm;
    logic             step;
    logic [IDX_W-1:0] step_idx;
    logic             angle;
    logic             mul_en;
    mul_sel_t         mul_sel;
    logic             out_load;
    out_kind_t        out_kind;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic zero;
    logic norm_done;
    logic gt_tol;
    logic lt_2tol;
    logic far;
  } dp_status_t;

  // atan(2^-i) with pi = 2^31
  function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10680350;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/gtph_ctrl.sv]
// ----------------------------------------------------------------------------
// gtph_ctrl
// Sequencer: run mode, navigation phase, CORDIC step count and result valid.
// ----------------------------------------------------------------------------
module gtph_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [gtph_pkg::MODE_W-1:0]   in_requested_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gtph_pkg::dp_cmd_t             cmd,
  input  gtph_pkg::dp_status_t          status
);
  import gtph_pkg::*;

  state_t           state_r, state_nxt;
  run_mode_t        run_r, run_nxt;
  nav_t             nav_r, nav_nxt;
  logic             init_r, init_nxt;
  logic             pause_r, pause_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  out_kind_t        kind_r, kind_nxt;
  logic             emit_fire;

  // Result register free or being drained this cycle
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // Next state and mode bookkeeping
  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    nav_nxt   = nav_r;
    init_nxt  = init_r;
    pause_nxt = pause_r;
    step_nxt  = step_r;
    kind_nxt  = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_MODE) begin
            // undefined mode codes are ignored
            if (in_requested_mode <= MODE_STOP) begin
              run_nxt = run_mode_t'(in_requested_mode);
            end
          end else begin
            case (run_r)
              MODE_INIT: begin
                run_nxt  = MODE_EXEC;
                init_nxt = 1'b1;
                nav_nxt  = NAV_FIX;
              end
              MODE_EXEC: begin
                pause_nxt = 1'b1;
                if (nav_r == NAV_DONE) begin
                  kind_nxt  = OUT_DONE;
                  run_nxt   = MODE_WAITING;
                  state_nxt = S_EMIT;
                end else begin
                  state_nxt = S_PREP;
                end
              end
              MODE_PAUSE: begin
                if (pause_r) begin
                  pause_nxt = 1'b0;
                  if (init_r) begin
                    kind_nxt  = OUT_ZERO;
                    state_nxt = S_EMIT;
                  end
                end
              end
              MODE_STOP: begin
                run_nxt = MODE_WAITING;
                if (init_r) begin
                  init_nxt  = 1'b0;
                  kind_nxt  = OUT_ZERO;
                  state_nxt = S_EMIT;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_PREP: begin
        step_nxt  = '0;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        // goal on top of the robot: bearing is zero, no rotation needed
        if (status.zero) begin
          state_nxt = S_ANGLE;
        end else if (status.norm_done) begin
          state_nxt = S_CORDIC;
        end
      end
      S_CORDIC: begin
        step_nxt = step_r + 5'd1;
        if (step_r == IDX_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_ANGLE;
        end
      end
      S_ANGLE: begin
        state_nxt = (nav_r == NAV_STRAIGHT) ? S_MUL_X : S_DECIDE;
      end
      S_MUL_X: state_nxt = S_MUL_Y;
      S_MUL_Y: state_nxt = S_MUL_D;
      S_MUL_D: state_nxt = S_DECIDE;
      S_DECIDE: begin
        state_nxt = S_IDLE;
        if (nav_r == NAV_FIX) begin
          if (status.gt_tol && status.lt_2tol) begin
            kind_nxt  = OUT_FINE;
            state_nxt = S_EMIT;
          end else if (status.gt_tol) begin
            kind_nxt  = OUT_COARSE;
            state_nxt = S_EMIT;
          end else begin
            nav_nxt = NAV_STRAIGHT;
          end
        end else begin
          if (status.far) begin
            kind_nxt  = OUT_FWD;
            state_nxt = S_EMIT;
          end else begin
            nav_nxt = NAV_DONE;
          end
          // heading drifted off: back to turning
          if (status.gt_tol) begin
            nav_nxt = NAV_FIX;
          end
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on load, held while stalled
  assign out_valid_nxt = emit_fire || (out_valid_r && out_stall);

  // Datapath commands
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.prep     = (state_r == S_PREP);
    cmd.norm     = (state_r == S_NORM) && !status.zero && !status.norm_done;
    cmd.step     = (state_r == S_CORDIC);
    cmd.step_idx = step_r;
    cmd.angle    = (state_r == S_ANGLE);
    cmd.out_load = emit_fire;
    cmd.out_kind = kind_r;
    case (state_r)
      S_MUL_X: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
      end
      S_MUL_Y: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
      end
      default: cmd.mul_en = 1'b0;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= MODE_WAITING;
      nav_r       <= NAV_FIX;
      init_r      <= 1'b0;
      pause_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      nav_r       <= nav_nxt;
      init_r      <= init_nxt;
      pause_r     <= pause_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Step count and pending result kind
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    kind_r <= kind_nxt;
  end

endmodule

[rtl/gtph_datapath.sv]
// ----------------------------------------------------------------------------
// gtph_datapath
// Settings, goal offset, CORDIC atan2, heading error, distance check and the
// result register.
// ----------------------------------------------------------------------------
module gtph_datapath #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [gtph_pkg::CFG_ADDR_W-1:0]          cfg_index,
  input  logic [((COORD_WIDTH > gtph_pkg::DTOL_W) ?
                 COORD_WIDTH : gtph_pkg::DTOL_W)-1:0] cfg_data,
  input  logic signed [COORD_WIDTH-1:0]            in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]            in_pos_y,
  input  logic signed [gtph_pkg::ANG_W-1:0]        in_heading,
  input  gtph_pkg::dp_cmd_t                        cmd,
  output gtph_pkg::dp_status_t                     status,
  output logic signed [gtph_pkg::CMD_W-1:0]        out_linear_cmd,
  output logic signed [gtph_pkg::CMD_W-1:0]        out_angular_cmd,
  output logic                                     out_goal_reached
);
  import gtph_pkg::*;

  localparam int MW = COORD_WIDTH + 1;                       // offset width
  localparam int NW = (MW > NORM_BIT + 1) ? MW : NORM_BIT + 1; // normalized
  localparam int XW = NW + 3;                                // CORDIC x/y
  localparam int CW = (MW > DTOL_W) ? MW : DTOL_W;           // compare width

  // Settings
  logic signed [COORD_WIDTH-1:0] tx_r, ty_r;
  logic [TOL_W-1:0]              htol_r;
  logic [DTOL_W-1:0]             dtol_r;
  logic [SPD_W-1:0]              fwd_r, turn_r, fine_r;

  // Working registers
  logic signed [MW-1:0]    dx_r, dy_r;
  logic [ANG_W-1:0]        heading_r;
  logic [MW-1:0]           ax_r, ay_r;
  logic                    zero_r;
  logic signed [XW-1:0]    x_r, y_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [ANG_W-1:0]        abs_err_r;
  logic                    neg_r;
  logic [PROD_W-1:0]       px_r, py_r, pd_r;

  // Result registers
  logic signed [CMD_W-1:0] lin_r, lin_nxt;
  logic signed [CMD_W-1:0] ang_r, ang_nxt;
  logic                    goal_r, goal_nxt;

  logic [MW-1:0]           ax_w, ay_w;
  logic [NW-1:0]           or_w;
  logic                    coarse_w;
  logic signed [XW-1:0]    xs_w, ys_w;
  logic signed [ACC_W-1:0] tab_w, rnd_w;
  logic [ACC_W-ANG_FRAC-1:0] rq_w;
  logic [ANG_W-1:0]        t_w, bearing_w, err_w;
  logic [CW-1:0]           axc_w, ayc_w, dc_w;
  logic [DTOL_W-1:0]       mul_a, mul_b;
  logic [PROD_W-1:0]       prod_w;
  logic [PROD_W:0]         sum_w;

  // Settings write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r   <= '0;
      ty_r   <= '0;
      htol_r <= HTOL_RST;
      dtol_r <= DTOL_RST;
      fwd_r  <= FWD_RST;
      turn_r <= TURN_RST;
      fine_r <= FINE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TARGET_X:  tx_r   <= cfg_data[COORD_WIDTH-1:0];
        CFG_TARGET_Y:  ty_r   <= cfg_data[COORD_WIDTH-1:0];
        CFG_HEAD_TOL:  htol_r <= cfg_data[TOL_W-1:0];
        CFG_DIST_TOL:  dtol_r <= cfg_data[DTOL_W-1:0];
        CFG_FWD_SPEED: fwd_r  <= cfg_data[SPD_W-1:0];
        CFG_TURN_SPD:  turn_r <= cfg_data[SPD_W-1:0];
        CFG_FINE_SPD:  fine_r <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset magnitudes
  assign ax_w = dx_r[MW-1] ? (~dx_r + 1'b1) : dx_r;
  assign ay_w = dy_r[MW-1] ? (~dy_r + 1'b1) : dy_r;

  // Normalization: shift by 8 while far below the target bit, else by 1
  assign or_w             = x_r[NW-1:0] | y_r[NW-1:0];
  assign status.norm_done = |or_w[NW-1:NORM_BIT];
  assign coarse_w         = ~|or_w[NW-1:COARSE_BIT];
  assign status.zero      = zero_r;

  // One CORDIC vectoring micro-rotation
  assign xs_w  = x_r >>> cmd.step_idx;
  assign ys_w  = y_r >>> cmd.step_idx;
  assign tab_w = ACC_W'(atan_entry(cmd.step_idx));

  // Round CORDIC angle to binary angle, clamp to 0 .. a quarter turn
  assign rnd_w = acc_r + ACC_W'(32768);
  assign rq_w  = rnd_w[ACC_W-1:ANG_FRAC];

  always_comb begin
    if (zero_r || acc_r[ACC_W-1]) begin
      t_w = '0;
    end else if (rq_w > (ACC_W - ANG_FRAC)'(QUARTER_TURN)) begin
      t_w = QUARTER_TURN;
    end else begin
      t_w = rq_w[ANG_W-1:0];
    end
  end

  // Quadrant mapping by offset signs
  always_comb begin
    case ({dx_r[MW-1], dy_r[MW-1]})
      2'b00:   bearing_w = t_w;
      2'b01:   bearing_w = ANG_W'(0) - t_w;
      2'b10:   bearing_w = HALF_TURN - t_w;
      2'b11:   bearing_w = t_w - HALF_TURN;
      default: bearing_w = t_w;
    endcase
  end

  // Heading error wraps modulo a full turn; exactly pi counts as negative
  assign err_w = bearing_w - heading_r;

  // Heading checks
  assign status.gt_tol  = abs_err_r > ANG_W'(htol_r);
  assign status.lt_2tol = abs_err_r < ANG_W'({htol_r, 1'b0});

  // Squared distance: one multiplier shared by the MUL_X, MUL_Y and MUL_D steps
  assign axc_w = CW'(ax_r);
  assign ayc_w = CW'(ay_r);
  assign dc_w  = CW'(dtol_r);

  always_comb begin
    case (cmd.mul_sel)
      MUL_X: begin
        mul_a = axc_w[DTOL_W-1:0];
        mul_b = axc_w[DTOL_W-1:0];
      end
      MUL_Y: begin
        mul_a = ayc_w[DTOL_W-1:0];
        mul_b = ayc_w[DTOL_W-1:0];
      end
      MUL_D: begin
        mul_a = dtol_r;
        mul_b = dtol_r;
      end
      default: begin
        mul_a = dtol_r;
        mul_b = dtol_r;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;
  assign sum_w  = {1'b0, px_r} + {1'b0, py_r};
  assign status.far = (axc_w > dc_w) || (ayc_w > dc_w) || (sum_w > {1'b0, pd_r});

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r      <= {tx_r[COORD_WIDTH-1], tx_r} - {in_pos_x[COORD_WIDTH-1], in_pos_x};
      dy_r      <= {ty_r[COORD_WIDTH-1], ty_r} - {in_pos_y[COORD_WIDTH-1], in_pos_y};
      heading_r <= in_heading;
    end
    if (cmd.prep) begin
      ax_r   <= ax_w;
      ay_r   <= ay_w;
      x_r    <= XW'(ax_w);
      y_r    <= XW'(ay_w);
      zero_r <= (ax_w == '0) && (ay_w == '0);
      acc_r  <= '0;
    end else if (cmd.norm) begin
      x_r <= coarse_w ? (x_r <<< COARSE_SHIFT) : (x_r <<< 1);
      y_r <= coarse_w ? (y_r <<< COARSE_SHIFT) : (y_r <<< 1);
    end else if (cmd.step) begin
      if (!y_r[XW-1]) begin
        x_r   <= x_r + ys_w;
        y_r   <= y_r - xs_w;
        acc_r <= acc_r + tab_w;
      end else begin
        x_r   <= x_r - ys_w;
        y_r   <= y_r + xs_w;
        acc_r <= acc_r - tab_w;
      end
    end
    if (cmd.angle) begin
      neg_r     <= err_w[ANG_W-1];
      abs_err_r <= err_w[ANG_W-1] ? (~err_w + 16'd1) : err_w;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_X:   px_r <= prod_w;
        MUL_Y:   py_r <= prod_w;
        MUL_D:   pd_r <= prod_w;
        default: ;
      endcase
    end
  end

  // Result composition
  always_comb begin
    lin_nxt  = '0;
    ang_nxt  = '0;
    goal_nxt = 1'b0;
    case (cmd.out_kind)
      OUT_ZERO: ;
      OUT_DONE: goal_nxt = 1'b1;
      OUT_FINE: begin
        lin_nxt = CMD_W'(fwd_r);
        ang_nxt = neg_r ? (CMD_W'(0) - CMD_W'(fine_r)) : CMD_W'(fine_r);
      end
      OUT_COARSE: begin
        ang_nxt = neg_r ? (CMD_W'(0) - CMD_W'(turn_r)) : CMD_W'(turn_r);
      end
      OUT_FWD: lin_nxt = CMD_W'(fwd_r);
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      lin_r  <= lin_nxt;
      ang_r  <= ang_nxt;
      goal_r <= goal_nxt;
    end
  end

  assign out_linear_cmd   = lin_r;
  assign out_angular_cmd  = ang_r;
  assign out_goal_reached = goal_r;

endmodule

[rtl/go_to_point_heading_controller.sv]
// ----------------------------------------------------------------------------
// go_to_point_heading_controller
// Go-to-point steering for a mobile robot: pose samples and mode requests in,
// velocity commands out.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_wr_en            cfg_index, cfg_data
//   in       in         in_valid / in_stall  operation, pos_x, pos_y, heading,
//                                            requested_mode
//   out      out        out_valid/out_stall  linear_cmd, angular_cmd,
//                                            goal_reached
//
// Mode requests and pose samples that do not run the CORDIC are taken in the
// idle state, then emit any result. A pose sample while executing runs the
// CORDIC atan2: prepare, normalization shifts, CORDIC_STEPS micro-rotations,
// angle, x, y and distance multiplies when going straight, decide and, with
// a result, emit. A goal on the robot's own position skips the CORDIC. One
// item is in work at a time. The result register lets the next item be taken
// while a result waits on out_stall; a further result then waits until that
// register drains. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module go_to_point_heading_controller #(
  parameter int COORD_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [gtph_pkg::CFG_ADDR_W-1:0]          cfg_index,
  input  logic [((COORD_WIDTH > gtph_pkg::DTOL_W) ?
                 COORD_WIDTH : gtph_pkg::DTOL_W)-1:0] cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_operation,
  input  logic signed [COORD_WIDTH-1:0]            in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]            in_pos_y,
  input  logic signed [gtph_pkg::ANG_W-1:0]        in_heading,
  input  logic [gtph_pkg::MODE_W-1:0]              in_requested_mode,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [gtph_pkg::CMD_W-1:0]        out_linear_cmd,
  output logic signed [gtph_pkg::CMD_W-1:0]        out_angular_cmd,
  output logic                                     out_goal_reached
);
  import gtph_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  gtph_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_requested_mode (in_requested_mode),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .status            (status)
  );

  // Arithmetic and settings
  gtph_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_heading       (in_heading),
    .cmd              (cmd),
    .status           (status),
    .out_linear_cmd   (out_linear_cmd),
    .out_angular_cmd  (out_angular_cmd),
    .out_goal_reached (out_goal_reached)
  );

endmodule

[rtl/gtph_checker.sv]
// ----------------------------------------------------------------------------
// gtph_checker
// Port-level checks of the go-to-point controller, bound to the top level.
// ----------------------------------------------------------------------------
module gtph_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               in_operation,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [gtph_pkg::CMD_W-1:0]  out_linear_cmd,
  input logic signed [gtph_pkg::CMD_W-1:0]  out_angular_cmd,
  input logic                               out_goal_reached
);
  import gtph_pkg::*;

  // Out of reset: nothing pending, input open
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state after reset not clean");

  // A result never appears in the cycle right after a transaction is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early after input transaction");

  // A mode request does not stall the input in the following cycle
  a_mode_req_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == OP_MODE) |=> !in_stall)
    else $error("mode request held the input");

  // Goal reached is a stop command
  a_goal_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_goal_reached |-> (out_linear_cmd == 0) && (out_angular_cmd == 0))
    else $error("goal reached with nonzero command");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_linear_cmd) &&
                               $stable(out_angular_cmd) && $stable(out_goal_reached))
    else $error("stalled result changed");

endmodule

bind go_to_point_heading_controller gtph_checker u_gtph_checker (.*);
